// File: hw/rtl/gravity_force_vector_macros.svh
// Assertion macros shared by the gravity force RTL.
`ifndef GRAVITY_FORCE_VECTOR_MACROS_SVH
`define GRAVITY_FORCE_VECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GFV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GFV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gfv_pkg.sv
// Package with widths, register codes and shared types of the gravity force block.
`default_nettype none

package gfv_pkg;

  localparam int POS_W      = 24;
  localparam int MASS_W     = 24;
  localparam int DELTA_W    = POS_W + 1;
  localparam int MAG_W      = POS_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DSQ_W      = SQ_W + 1;
  localparam int GRAV_W     = 32;
  localparam int BOUND_W    = 48;
  localparam int PROD_W     = 2 * MASS_W;
  localparam int HALF_W     = PROD_W / 2;
  localparam int GP_W       = GRAV_W + PROD_W;
  localparam int NUM_W      = GP_W + MAG_W;
  localparam int SQV_W      = 64;
  localparam int SQRT_SHIFT = 14;
  localparam int SQRT_STEPS = SQV_W / 2;
  localparam int ROOT_W     = SQV_W / 2;
  localparam int DEN_W      = BOUND_W + ROOT_W + 1;
  localparam int QUO_W      = 32;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int FORCE_W    = 32;

  localparam int IN_DATA_W  = 4 * POS_W + 2 * MASS_W;
  localparam int OUT_DATA_W = 2 * FORCE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BOUND_W;

  localparam logic [GRAV_W-1:0]  GRAV_RESET    = GRAV_W'(32'h0100_0000);
  localparam logic [BOUND_W-1:0] MIN_DSQ_RESET = BOUND_W'(48'h0000_0001_0000);
  localparam logic [BOUND_W-1:0] MAX_DSQ_RESET = {BOUND_W{1'b1}};

  localparam logic [FORCE_W-1:0] POS_LIMIT = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEG_LIMIT = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAV_CONSTANT,
    REG_MIN_DIST_SQ,
    REG_MAX_DIST_SQ
  } cfg_reg_e;

  // Divider result: nonzero numerator, zero divisor or quotient out of range, quotient.
  typedef struct packed {
    logic             nz;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/gfv_div.sv
// Pipelined restoring divider, one quotient bit per stage, range check up front.
`default_nettype none

module gfv_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [gfv_pkg::NUM_W-1:0]  num_i,
  input  logic [gfv_pkg::DEN_W-1:0]  den_i,
  output gfv_pkg::div_stat_t         stat_o
);
  import gfv_pkg::*;

  localparam int CMP_W = DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [0:QUO_W];
  logic [DEN_W-1:0] den_q [0:QUO_W];
  logic [QUO_W-1:0] quo_q [0:QUO_W];
  logic             nz_q  [0:QUO_W];
  logic             ovf_q [0:QUO_W];

  // Flag a zero divisor or a quotient of 2^QUO_W or more.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      nz_q[0]  <= |num_i;
      ovf_q[0] <= (den_i == '0) ||
                  ({{(CMP_W-NUM_W){1'b0}}, num_i} >= {den_i, {QUO_W{1'b0}}});
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int SH = QUO_W - k;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rext;
    logic [CMP_W-1:0] diff;
    logic             take;

    assign dsh  = {{(CMP_W-DEN_W){1'b0}}, den_q[k-1]} << SH;
    assign rext = {{(CMP_W-NUM_W){1'b0}}, rem_q[k-1]};
    assign take = rext >= dsh;
    assign diff = rext - dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[NUM_W-1:0] : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], take};
        nz_q[k]  <= nz_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign stat_o = '{nz: nz_q[QUO_W], ovf: ovf_q[QUO_W], quo: quo_q[QUO_W]};

endmodule

`default_nettype wire

// File: hw/rtl/gravity_force_vector.sv
// Throughput: one pair per cycle while the output is not stalled; the 32-stage
// square root and the two 33-stage dividers each take a new operand every cycle,
// so the whole chain is one pipe.
// Stalls: the pipe holds while a result waits; a one-entry skid buffer still
// takes one more input. Reset clears all valid bits and loads the register defaults.
`default_nettype none

`include "gravity_force_vector_macros.svh"

module gravity_force_vector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // first_x, first_y, second_x, second_y, first_mass, second_mass
  input  logic [gfv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // force_x, force_y
  output logic [gfv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // saturated
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [gfv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gfv_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import gfv_pkg::*;

  // S1..S4, root steps, two multiply stages, divider.
  localparam int PIPE_DEPTH = 4 + SQRT_STEPS + 2 + DIV_LAT;

  // ---------------------------------------------------------------- config
  logic [GRAV_W-1:0]  grav_q;
  logic [BOUND_W-1:0] min_dsq_q;
  logic [BOUND_W-1:0] max_dsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q    <= GRAV_RESET;
      min_dsq_q <= MIN_DSQ_RESET;
      max_dsq_q <= MAX_DSQ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRAV_CONSTANT: grav_q    <= cfg_wdata_i[GRAV_W-1:0];
        REG_MIN_DIST_SQ:   min_dsq_q <= cfg_wdata_i[BOUND_W-1:0];
        REG_MAX_DIST_SQ:   max_dsq_q <= cfg_wdata_i[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // The whole pipe advances together whenever the output register can move.
  logic                 en;
  logic                 out_valid_q;
  logic                 skid_valid_q, skid_valid_d;
  logic [IN_DATA_W-1:0] skid_data_q;
  logic                 in_take;
  logic                 src_valid;
  logic [IN_DATA_W-1:0] src_data;
  logic [PIPE_DEPTH-1:0] vld_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign src_valid     = skid_valid_q || in_take;
  assign src_data      = skid_valid_q ? skid_data_q : s_axis_tdata;

  // Park a transfer that arrives during a stall; drain it on the next advance.
  always_comb begin
    skid_valid_d = skid_valid_q;
    if (en) begin
      skid_valid_d = 1'b0;
    end else if (in_take) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
      if (en) begin
        vld_q       <= {vld_q[PIPE_DEPTH-2:0], src_valid};
        out_valid_q <= vld_q[PIPE_DEPTH-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_take) begin
      skid_data_q <= s_axis_tdata;
    end
  end

  // ------------------------------------------------------ S1: deltas, mass
  logic signed [POS_W-1:0] ax, ay, bx, by;
  logic [MASS_W-1:0]       ma, mb;

  assign ax = $signed(src_data[0*POS_W +: POS_W]);
  assign ay = $signed(src_data[1*POS_W +: POS_W]);
  assign bx = $signed(src_data[2*POS_W +: POS_W]);
  assign by = $signed(src_data[3*POS_W +: POS_W]);
  assign ma = src_data[4*POS_W +: MASS_W];
  assign mb = src_data[4*POS_W+MASS_W +: MASS_W];

  logic signed [DELTA_W-1:0] dx_s1_q, dy_s1_q;
  logic [PROD_W-1:0]         p_s1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_s1_q <= DELTA_W'(bx) - DELTA_W'(ax);
      dy_s1_q <= DELTA_W'(by) - DELTA_W'(ay);
      p_s1_q  <= PROD_W'(ma) * PROD_W'(mb);
    end
  end

  // ----------------------------------------- S2: squares, G * P partials
  logic signed [2*DELTA_W-1:0] dx_sq, dy_sq;
  logic [DELTA_W-1:0]          dx_abs, dy_abs;

  assign dx_sq  = dx_s1_q * dx_s1_q;
  assign dy_sq  = dy_s1_q * dy_s1_q;
  assign dx_abs = dx_s1_q[DELTA_W-1] ? DELTA_W'(-dx_s1_q) : DELTA_W'(dx_s1_q);
  assign dy_abs = dy_s1_q[DELTA_W-1] ? DELTA_W'(-dy_s1_q) : DELTA_W'(dy_s1_q);

  logic [SQ_W-1:0]          dxsq_s2_q, dysq_s2_q;
  logic [GRAV_W+HALF_W-1:0] gpl_s2_q, gph_s2_q;
  logic                     negx_s2_q, negy_s2_q;
  logic [MAG_W-1:0]         magx_s2_q, magy_s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxsq_s2_q <= dx_sq[SQ_W-1:0];
      dysq_s2_q <= dy_sq[SQ_W-1:0];
      gpl_s2_q  <= (GRAV_W+HALF_W)'(grav_q) * (GRAV_W+HALF_W)'(p_s1_q[HALF_W-1:0]);
      gph_s2_q  <= (GRAV_W+HALF_W)'(grav_q) * (GRAV_W+HALF_W)'(p_s1_q[PROD_W-1:HALF_W]);
      negx_s2_q <= dx_s1_q[DELTA_W-1];
      negy_s2_q <= dy_s1_q[DELTA_W-1];
      magx_s2_q <= dx_abs[MAG_W-1:0];
      magy_s2_q <= dy_abs[MAG_W-1:0];
    end
  end

  // ------------------------------------------------- S3: |d|^2 and G * P
  logic [DSQ_W-1:0] dsq_s3_q;
  logic [GP_W-1:0]  gp_s3_q;
  logic             negx_s3_q, negy_s3_q;
  logic [MAG_W-1:0] magx_s3_q, magy_s3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq_s3_q  <= DSQ_W'(dxsq_s2_q) + DSQ_W'(dysq_s2_q);
      gp_s3_q   <= GP_W'(gpl_s2_q) + {gph_s2_q, {HALF_W{1'b0}}};
      negx_s3_q <= negx_s2_q;
      negy_s3_q <= negy_s2_q;
      magx_s3_q <= magx_s2_q;
      magy_s3_q <= magy_s2_q;
    end
  end

  // ----------------------------------------- S4: clamp, load root operand
  logic [BOUND_W-1:0] dsq_clamped;

  // With inverted bounds, values below the lower bound take it; all others take the upper.
  always_comb begin
    if (dsq_s3_q < DSQ_W'(min_dsq_q)) begin
      dsq_clamped = min_dsq_q;
    end else if (dsq_s3_q > DSQ_W'(max_dsq_q)) begin
      dsq_clamped = max_dsq_q;
    end else begin
      dsq_clamped = dsq_s3_q[BOUND_W-1:0];
    end
  end

  // Root line: remainder, partial root, and everything that rides along.
  logic [SQV_W-1:0]   sq_v_q  [0:SQRT_STEPS];
  logic [SQV_W-1:0]   sq_r_q  [0:SQRT_STEPS];
  logic [GP_W-1:0]    gp_l_q  [0:SQRT_STEPS];
  logic [BOUND_W-1:0] dsqc_l_q[0:SQRT_STEPS];
  logic               negx_l_q[0:SQRT_STEPS];
  logic               negy_l_q[0:SQRT_STEPS];
  logic [MAG_W-1:0]   magx_l_q[0:SQRT_STEPS];
  logic [MAG_W-1:0]   magy_l_q[0:SQRT_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_v_q[0]   <= SQV_W'({dsq_s3_q, {SQRT_SHIFT{1'b0}}});
      sq_r_q[0]   <= '0;
      gp_l_q[0]   <= gp_s3_q;
      dsqc_l_q[0] <= dsq_clamped;
      negx_l_q[0] <= negx_s3_q;
      negy_l_q[0] <= negy_s3_q;
      magx_l_q[0] <= magx_s3_q;
      magy_l_q[0] <= magy_s3_q;
    end
  end

  // One root bit per stage, trial bit walking down two places each time.
  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_root
    localparam int BIT_POS = SQV_W - 2 * k;
    logic [SQV_W-1:0] trial_bit;
    logic [SQV_W:0]   trial;
    logic             take;

    assign trial_bit = SQV_W'(1) << BIT_POS;
    assign trial     = {1'b0, sq_r_q[k-1]} + {1'b0, trial_bit};
    assign take      = {1'b0, sq_v_q[k-1]} >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_v_q[k]   <= take ? (sq_v_q[k-1] - trial[SQV_W-1:0]) : sq_v_q[k-1];
        sq_r_q[k]   <= take ? ((sq_r_q[k-1] >> 1) + trial_bit) : (sq_r_q[k-1] >> 1);
        gp_l_q[k]   <= gp_l_q[k-1];
        dsqc_l_q[k] <= dsqc_l_q[k-1];
        negx_l_q[k] <= negx_l_q[k-1];
        negy_l_q[k] <= negy_l_q[k-1];
        magx_l_q[k] <= magx_l_q[k-1];
        magy_l_q[k] <= magy_l_q[k-1];
      end
    end
  end

  // ------------------------------------------- M1: numerator/denominator parts
  localparam int S2_W  = ROOT_W + 1;
  localparam int DP_W  = HALF_W + S2_W;
  localparam int NP_W  = 32 + MAG_W;
  localparam int NPC_W = (GP_W - 64) + MAG_W;

  logic [S2_W-1:0] root2;
  assign root2 = {sq_r_q[SQRT_STEPS][ROOT_W-1:0], 1'b0};

  logic [DP_W-1:0]  denl_m1_q, denh_m1_q;
  logic [NP_W-1:0]  pxa_m1_q, pxb_m1_q, pya_m1_q, pyb_m1_q;
  logic [NPC_W-1:0] pxc_m1_q, pyc_m1_q;
  logic             negx_m1_q, negy_m1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      denl_m1_q <= DP_W'(dsqc_l_q[SQRT_STEPS][HALF_W-1:0]) * DP_W'(root2);
      denh_m1_q <= DP_W'(dsqc_l_q[SQRT_STEPS][BOUND_W-1:HALF_W]) * DP_W'(root2);
      pxa_m1_q  <= NP_W'(gp_l_q[SQRT_STEPS][31:0])  * NP_W'(magx_l_q[SQRT_STEPS]);
      pxb_m1_q  <= NP_W'(gp_l_q[SQRT_STEPS][63:32]) * NP_W'(magx_l_q[SQRT_STEPS]);
      pxc_m1_q  <= NPC_W'(gp_l_q[SQRT_STEPS][GP_W-1:64]) * NPC_W'(magx_l_q[SQRT_STEPS]);
      pya_m1_q  <= NP_W'(gp_l_q[SQRT_STEPS][31:0])  * NP_W'(magy_l_q[SQRT_STEPS]);
      pyb_m1_q  <= NP_W'(gp_l_q[SQRT_STEPS][63:32]) * NP_W'(magy_l_q[SQRT_STEPS]);
      pyc_m1_q  <= NPC_W'(gp_l_q[SQRT_STEPS][GP_W-1:64]) * NPC_W'(magy_l_q[SQRT_STEPS]);
      negx_m1_q <= negx_l_q[SQRT_STEPS];
      negy_m1_q <= negy_l_q[SQRT_STEPS];
    end
  end

  // --------------------------------------------------- M2: sum the parts
  logic [DEN_W-1:0] den_m2_q;
  logic [NUM_W-1:0] numx_m2_q, numy_m2_q;
  logic             negx_m2_q, negy_m2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_m2_q  <= DEN_W'(denl_m1_q) + DEN_W'({denh_m1_q, {HALF_W{1'b0}}});
      numx_m2_q <= NUM_W'(pxa_m1_q) + NUM_W'({pxb_m1_q, 32'b0}) + NUM_W'({pxc_m1_q, 64'b0});
      numy_m2_q <= NUM_W'(pya_m1_q) + NUM_W'({pyb_m1_q, 32'b0}) + NUM_W'({pyc_m1_q, 64'b0});
      negx_m2_q <= negx_m1_q;
      negy_m2_q <= negy_m1_q;
    end
  end

  // ------------------------------------------------------------- dividers
  div_stat_t stat_x, stat_y;

  gfv_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numx_m2_q),
    .den_i  (den_m2_q),
    .stat_o (stat_x)
  );

  gfv_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numy_m2_q),
    .den_i  (den_m2_q),
    .stat_o (stat_y)
  );

  // Hold the signs alongside the divider stages.
  logic negx_d_q [0:DIV_LAT-1];
  logic negy_d_q [0:DIV_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      negx_d_q[0] <= negx_m2_q;
      negy_d_q[0] <= negy_m2_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        negx_d_q[i] <= negx_d_q[i-1];
        negy_d_q[i] <= negy_d_q[i-1];
      end
    end
  end

  // ---------------------------------------------- saturate, sign, output
  // Zero numerator gives zero; zero divisor or out-of-range quotient clips.
  function automatic logic [FORCE_W:0] force_comp(div_stat_t st, logic neg);
    logic [FORCE_W-1:0] lim;
    logic [FORCE_W-1:0] mag;
    logic               sat;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    sat = 1'b0;
    mag = '0;
    if (!st.nz) begin
      mag = '0;
    end else if (st.ovf || (st.quo > lim)) begin
      mag = lim;
      sat = 1'b1;
    end else begin
      mag = st.quo;
    end
    return {sat, neg ? FORCE_W'(-mag) : mag};
  endfunction

  logic [FORCE_W:0]   res_x, res_y;
  logic [FORCE_W-1:0] fx_q, fy_q;
  logic               sat_q;

  assign res_x = force_comp(stat_x, negx_d_q[DIV_LAT-1]);
  assign res_y = force_comp(stat_y, negy_d_q[DIV_LAT-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q  <= res_x[FORCE_W-1:0];
      fy_q  <= res_y[FORCE_W-1:0];
      sat_q <= res_x[FORCE_W] || res_y[FORCE_W];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {fy_q, fx_q};
  assign m_axis_tuser  = sat_q;

  // ----------------------------------------------------------- assertions
  `GFV_ASSERT_NXT(a_skid_fill, in_take && !en, skid_valid_q,
    "stalled transfer not parked in skid buffer")
  `GFV_ASSERT_NXT(a_skid_drain, skid_valid_q && en, !skid_valid_q,
    "skid buffer not drained on advance")
  `GFV_ASSERT_NOW(a_sat_limit, out_valid_q && sat_q,
    fx_q == POS_LIMIT || fx_q == NEG_LIMIT || fy_q == POS_LIMIT || fy_q == NEG_LIMIT,
    "saturation flag without a clipped component")
  `GFV_ASSERT_NOW(a_zero_nosat, out_valid_q && fx_q == '0 && fy_q == '0, !sat_q,
    "zero force reported as saturated")

endmodule

`default_nettype wire
